### hdl/bga_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery gauge package
// Shared widths, constants, controller states and the command and status
// structures that join the controller to the datapath.
// ----------------------------------------------------------------------------
package bga_pkg;

    // Most good samples that one burst may add up.
    localparam int MAX_SAMPLES = 8;

    localparam int SAMPLE_W  = 12;
    localparam int SUM_W     = 16;
    localparam int COUNT_W   = 5;
    localparam int RAW_W     = 12;
    localparam int MV_W      = 13;
    localparam int PCT_W     = 7;
    localparam int CFG_W     = 13;

    // Serial divider operand widths.
    localparam int DIVD_W    = 21;
    localparam int DIVS_W    = 13;
    localparam int DIV_CNT_W = $clog2(DIVD_W);

    // Register map: one register, index taken from paddr[2].
    localparam logic REG_FULL_MV = 1'b0;
    localparam logic [CFG_W-1:0] FULL_MV_RESET = 13'd4120;

    // 3300 * 5000 / (4095 * 4000) reduces to 275 / 273, which is one plus
    // 2 / 273. The fractional part for 2 * raw is taken as
    // (2 * raw * 3841) >> 20, exact over the whole range of 2 * raw.
    localparam int              VOLT_PROD_W = 25;
    localparam int              VOLT_SHIFT  = 20;
    localparam logic [11:0]     VOLT_RECIP  = 12'd3841;

    // Charge curve breakpoints in millivolts.
    localparam logic [MV_W-1:0] MV_EMPTY = 13'd3300;
    localparam logic [MV_W-1:0] MV_BP1   = 13'd3600;
    localparam logic [MV_W-1:0] MV_BP2   = 13'd3800;
    localparam logic [MV_W-1:0] MV_BP3   = 13'd4000;

    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;
    localparam logic [PCT_W-1:0] PCT_BP1   = 7'd20;
    localparam logic [PCT_W-1:0] PCT_BP2   = 7'd60;
    localparam logic [PCT_W-1:0] PCT_BP3   = 7'd90;
    localparam logic [PCT_W-1:0] PCT_FULL  = 7'd100;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_WAIT_MEAN,
        ST_VOLT,
        ST_PCT,
        ST_WAIT_PCT,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        DIV_MEAN,
        DIV_PCT
    } div_sel_t;

    typedef struct packed {
        logic     accept;
        logic     div_start;
        div_sel_t div_sel;
        logic     cap_mean;
        logic     cap_volt;
        logic     pct_direct_load;
        logic     cap_pct;
        logic     emit;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic div_busy;
        logic div_done;
        logic pct_direct;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

### hdl/bga_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery gauge serial divider
// Restoring division, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module bga_div (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         start,
    input  wire logic [bga_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [bga_pkg::DIVS_W-1:0]   divisor,
    output logic                              busy,
    output logic                              done,
    output logic [bga_pkg::DIVD_W-1:0]        quotient
);
    import bga_pkg::*;

    logic [DIVD_W-1:0]    quo_reg, quo_next;
    logic [DIVS_W-1:0]    rem_reg, rem_next;
    logic [DIVS_W-1:0]    dvs_reg, dvs_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIVS_W:0]      trial;
    logic [DIVS_W:0]      diff;
    logic                 q_bit;

    always_comb begin
        trial = {rem_reg, quo_reg[DIVD_W-1]};
        diff  = trial - {1'b0, dvs_reg};
        q_bit = (trial >= {1'b0, dvs_reg});

        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;

        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = DIV_CNT_W'(DIVD_W - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[DIVD_W-2:0], q_bit};
            rem_next = q_bit ? diff[DIVS_W-1:0] : trial[DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

### hdl/bga_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery gauge datapath
// Sample accumulator, operand selection for the shared divider, held result
// registers and the output register of the result channel.
// ----------------------------------------------------------------------------
module bga_dp (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire bga_pkg::cmd_t                 cmd,
    input  wire logic [bga_pkg::SAMPLE_W-1:0]  sample,
    input  wire logic                          sample_ok,
    input  wire logic [bga_pkg::CFG_W-1:0]     full_mv,
    input  wire logic                          m_tready,
    output bga_pkg::status_t                   sts,
    output logic                               m_tvalid,
    output logic [31:0]                        m_tdata,
    output logic [0:0]                         m_tuser
);
    import bga_pkg::*;

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [RAW_W-1:0]   raw_reg;
    logic [MV_W-1:0]    mv_reg;
    logic [PCT_W-1:0]   pct_reg;
    logic [PCT_W-1:0]   pct_off_reg;
    logic               out_valid_reg;
    logic [31:0]        out_data_reg;
    logic               out_user_reg;

    logic [DIVD_W-1:0]  div_dividend;
    logic [DIVS_W-1:0]  div_divisor;
    logic [DIVD_W-1:0]  div_quot;
    logic               div_busy;
    logic               div_done;

    logic [VOLT_PROD_W-1:0] volt_prod;
    logic [MV_W-1:0]        volt_mv;
    logic [MV_W-1:0]    seg_diff;
    logic [5:0]         seg_gain;
    logic [DIVS_W-1:0]  seg_den;
    logic [PCT_W-1:0]   seg_off;
    logic               seg_direct;
    logic [PCT_W-1:0]   seg_direct_val;
    logic [DIVD_W-1:0]  seg_prod;

    // Accumulate good samples up to the burst limit; cleared once per result.
    always_comb begin
        sum_next   = sum_reg;
        count_next = count_reg;
        if (cmd.emit) begin
            sum_next   = '0;
            count_next = '0;
        end else if (cmd.accept && sample_ok && (count_reg < COUNT_W'(MAX_SAMPLES))) begin
            sum_next   = sum_reg + SUM_W'(sample);
            count_next = count_reg + 1'b1;
        end
    end

    // Piecewise-linear charge curve: pick the segment and its operands.
    always_comb begin
        seg_diff       = '0;
        seg_gain       = '0;
        seg_den        = DIVS_W'(1);
        seg_off        = PCT_EMPTY;
        seg_direct     = 1'b0;
        seg_direct_val = PCT_EMPTY;
        if (mv_reg <= MV_EMPTY) begin
            seg_direct     = 1'b1;
            seg_direct_val = PCT_EMPTY;
        end else if (mv_reg < MV_BP1) begin
            seg_diff = mv_reg - MV_EMPTY;
            seg_gain = 6'd20;
            seg_den  = DIVS_W'(300);
            seg_off  = PCT_EMPTY;
        end else if (mv_reg < MV_BP2) begin
            seg_diff = mv_reg - MV_BP1;
            seg_gain = 6'd40;
            seg_den  = DIVS_W'(200);
            seg_off  = PCT_BP1;
        end else if (mv_reg < MV_BP3) begin
            seg_diff = mv_reg - MV_BP2;
            seg_gain = 6'd30;
            seg_den  = DIVS_W'(200);
            seg_off  = PCT_BP2;
        end else if (mv_reg < full_mv) begin
            seg_diff = mv_reg - MV_BP3;
            seg_gain = 6'd10;
            seg_den  = full_mv - MV_BP3;
            seg_off  = PCT_BP3;
        end else begin
            seg_direct     = 1'b1;
            seg_direct_val = PCT_FULL;
        end
    end

    assign seg_prod  = DIVD_W'(seg_diff) * DIVD_W'(seg_gain);

    // Voltage is the mean plus the truncated 2 * mean / 273.
    assign volt_prod = VOLT_PROD_W'({raw_reg, 1'b0}) * VOLT_PROD_W'(VOLT_RECIP);
    assign volt_mv   = MV_W'(raw_reg) + MV_W'(volt_prod[VOLT_PROD_W-1:VOLT_SHIFT]);

    always_comb begin
        case (cmd.div_sel)
            DIV_MEAN: begin
                div_dividend = DIVD_W'(sum_reg);
                div_divisor  = DIVS_W'(count_reg);
            end
            DIV_PCT: begin
                div_dividend = seg_prod;
                div_divisor  = seg_den;
            end
            default: begin
                div_dividend = '0;
                div_divisor  = DIVS_W'(1);
            end
        endcase
    end

    bga_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            count_reg     <= '0;
            raw_reg       <= '0;
            mv_reg        <= '0;
            pct_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            sum_reg   <= sum_next;
            count_reg <= count_next;
            if (cmd.cap_mean) begin
                raw_reg <= div_quot[RAW_W-1:0];
            end
            if (cmd.cap_volt) begin
                mv_reg <= volt_mv;
            end
            if (cmd.pct_direct_load) begin
                pct_reg <= seg_direct_val;
            end else if (cmd.cap_pct) begin
                pct_reg <= pct_off_reg + div_quot[PCT_W-1:0];
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_start && (cmd.div_sel == DIV_PCT)) begin
            pct_off_reg <= seg_off;
        end
        if (cmd.emit) begin
            out_data_reg <= {pct_reg, mv_reg, raw_reg};
            out_user_reg <= (count_reg != '0);
        end
    end

    assign sts.count_zero = (count_reg == '0);
    assign sts.div_busy   = div_busy;
    assign sts.div_done   = div_done;
    assign sts.pct_direct = seg_direct;
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_user_reg;

endmodule
`default_nettype wire

### hdl/bga_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery gauge controller
// Sequences accumulation, the two divisions, the voltage step and the
// hand-over of a result.
// ----------------------------------------------------------------------------
module bga_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    input  wire logic              s_tlast,
    input  wire bga_pkg::status_t  sts,
    output logic                   s_tready,
    output bga_pkg::cmd_t          cmd
);
    import bga_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tlast) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                state_next = sts.count_zero ? ST_EMIT : ST_WAIT_MEAN;
            end
            ST_WAIT_MEAN: begin
                if (sts.div_done) begin
                    state_next = ST_VOLT;
                end
            end
            ST_VOLT: begin
                state_next = ST_PCT;
            end
            ST_PCT: begin
                state_next = sts.pct_direct ? ST_EMIT : ST_WAIT_PCT;
            end
            ST_WAIT_PCT: begin
                if (sts.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd      = '0;
        cmd.div_sel = DIV_MEAN;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready   = 1'b1;
                cmd.accept = s_tvalid;
            end
            ST_CHECK: begin
                cmd.div_start = !sts.count_zero;
                cmd.div_sel   = DIV_MEAN;
            end
            ST_WAIT_MEAN: begin
                cmd.cap_mean = sts.div_done;
            end
            ST_VOLT: begin
                cmd.cap_volt = 1'b1;
            end
            ST_PCT: begin
                cmd.pct_direct_load = sts.pct_direct;
                cmd.div_start       = !sts.pct_direct;
                cmd.div_sel         = DIV_PCT;
            end
            ST_WAIT_PCT: begin
                cmd.cap_pct = sts.div_done;
                cmd.div_sel = DIV_PCT;
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

### hdl/battery_gauge_average_to_percent.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Battery gauge: burst average to voltage and state of charge
// Averages a burst of conversion attempts and turns the mean into battery
// millivolts and a piecewise-linear charge percentage.
// ----------------------------------------------------------------------------
// Usage:
// Each input item is one conversion attempt: the 12-bit sample in s_tdata,
// its success flag in s_tuser and the end of the burst in s_tlast. Up to
// eight good samples of a burst are summed; further good ones are dropped.
// An attempt without s_tlast gives no result and leaves s_tready high.
// The attempt carrying s_tlast gives exactly one result item on the m_
// channel, and s_tready stays low from then until that result is handed to
// the output register. With a good sample in the burst, the mean and the
// percentage each take one pass through a 21-step serial divider and the
// voltage is formed by a reciprocal multiplication; the percentage division
// is skipped when the voltage lies at or below 3300 mV or at or above the
// full point. A burst without a good sample skips both divisions and gives
// its result with m_tuser low and the previous values repeated.
// The result sits in an output register; while the receiver stalls, further
// attempts are still taken and a following burst is still worked out, but
// its hand-over waits, with s_tready low, until the output register is free.
// Reset clears the accumulator, the held values and the output register, and
// sets full_millivolts to 4120. full_millivolts is written over the APB port
// at byte address 0 and should only be changed while no burst is pending.
// ----------------------------------------------------------------------------
module battery_gauge_average_to_percent (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input attempts
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [11:0] sample, [15:12] zero
    input  wire logic [0:0]  s_tuser,   // [0] sample_ok
    input  wire logic        s_tlast,   // last_attempt
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [11:0] average_raw,
                                        // [24:12] battery_millivolts,
                                        // [31:25] charge_percent
    output logic [0:0]       m_tuser,   // [0] result_valid
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import bga_pkg::*;

    logic [CFG_W-1:0] full_mv_reg;
    logic             reg_index;
    cmd_t             cmd;
    status_t          sts;

    // The register index is the word address; only one register exists.
    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            full_mv_reg <= FULL_MV_RESET;
        end else if (psel && penable && pwrite && pready && (reg_index == REG_FULL_MV)) begin
            full_mv_reg <= pwdata[CFG_W-1:0];
        end
    end

    always_comb begin
        unique case (reg_index)
            REG_FULL_MV: prdata = 32'(full_mv_reg);
            default:     prdata = '0;
        endcase
    end

    bga_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .sts      (sts),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    bga_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .sample_ok (s_tuser[0]),
        .full_mv   (full_mv_reg),
        .m_tready  (m_tready),
        .sts       (sts),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // The shared divider is never running while new attempts are taken.
    a_idle_div: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !sts.div_busy)
        else $error("divider busy while attempts are accepted");

    // A presented result never shows a charge above one hundred percent.
    a_pct_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:25] <= 7'd100))
        else $error("charge percentage out of range");

    // The computed voltage never exceeds full-scale input.
    a_mv_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[24:12] <= 13'd4125))
        else $error("battery voltage out of range");

    // A fresh result only follows the controller handing one over.
    a_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> $past(cmd.emit))
        else $error("result appeared without a hand-over");

endmodule
`default_nettype wire

### dv/tb_battery_gauge_average_to_percent.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the battery gauge burst averager
// Drives bursts of conversion attempts into the block and predicts every
// result item in the testbench itself: mean, voltage and charge percentage.
// A short table of hand-picked attempts comes first. Random bursts follow
// under several full-scale settings written over APB, with random idling on
// both channels, a long output hold-off and a pause until the block is empty.
// ----------------------------------------------------------------------------
module tb_battery_gauge_average_to_percent;

    import bga_pkg::*;

    localparam int          HALF_PERIOD   = 5;
    localparam int          HOLD_CYCLES   = 400;   // length of the long output stall
    localparam int          SETTLE_CYCLES = 100;   // exceeds the worst result latency
    localparam int          PHASE_ITEMS   = 226;
    localparam int          SHOW_LIMIT    = 10;
    localparam logic [2:0]  FULL_MV_ADDR  = {REG_FULL_MV, 2'b00};

    // One result item, field by field.
    typedef struct packed {
        bit [11:0] raw;
        bit [12:0] mv;
        bit [6:0]  pct;
        bit        ok;
    } gauge_reading_t;

    // One row of the directed table. Where typed is set, want holds the
    // result that the row is known to give; otherwise the predictor decides.
    typedef struct packed {
        bit [11:0]      smp;
        bit             ok;
        bit             lst;
        bit             typed;
        gauge_reading_t want;
    } attempt_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // Controls shared between the stimulus and the receiver.
    logic        steady   = 1'b0;   // no idling on either side while high
    logic        hold_req = 1'b0;   // each toggle starts one long output stall

    // Predictor state: the accumulator, the held values and the full point.
    bit [15:0]   acc_sum   = '0;
    bit [4:0]    acc_count = '0;
    bit [11:0]   held_raw  = '0;
    bit [12:0]   held_mv   = '0;
    bit [6:0]    held_pct  = '0;
    bit [12:0]   full_mv   = 13'd4120;

    gauge_reading_t expected_readings[$];

    int failures        = 0;
    int attempts_sent   = 0;
    int bursts_sent     = 0;
    int readings_seen   = 0;
    int empty_readings  = 0;
    int settings_tried  = 1;

    battery_gauge_average_to_percent dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Charge curve: flat at zero up to 3300 mV, then straight segments to
    // 20 % at 3600, 60 % at 3800, 90 % at 4000 and 100 % at the full point.
    // With the full point at or below 4000 mV the last segment vanishes and
    // anything from 4000 mV up reads full, so its division is never reached.
    function automatic bit [6:0] charge_from_mv(input int unsigned mv,
                                                input int unsigned full);
        if (mv <= 3300)
            return 7'd0;
        if (mv < 3600)
            return 7'((mv - 3300) * 20 / 300);
        if (mv < 3800)
            return 7'(20 + (mv - 3600) * 40 / 200);
        if (mv < 4000)
            return 7'(60 + (mv - 3800) * 30 / 200);
        if (mv < full)
            return 7'(90 + (mv - 4000) * 10 / (full - 4000));
        return 7'd100;
    endfunction

    // Takes one accepted attempt. Only the attempt that closes a burst gives
    // a reading; a burst without a good sample repeats the held values.
    function automatic gauge_reading_t gauge_step(input bit [11:0] smp, input bit ok,
                                                  input bit lst, output bit emits);
        gauge_reading_t r;
        r = '0;
        // Good samples beyond the burst limit are dropped.
        if (ok && acc_count < 5'(MAX_SAMPLES)) begin
            acc_sum   = acc_sum + 16'(smp);
            acc_count = acc_count + 5'd1;
        end
        emits = lst;
        if (lst) begin
            if (acc_count != 0) begin
                held_raw = 12'(acc_sum / acc_count);
                // Divider ratio 3300/4095 with the 5000/4000 sense divider.
                held_mv  = 13'((longint'(held_raw) * 3300 * 5000) / (4095 * 4000));
                held_pct = charge_from_mv(held_mv, full_mv);
                r.ok     = 1'b1;
            end
            acc_sum   = '0;
            acc_count = '0;
            r.raw = held_raw;
            r.mv  = held_mv;
            r.pct = held_pct;
        end
        return r;
    endfunction

    function automatic void note_failure(input string msg);
        failures++;
        if (failures <= SHOW_LIMIT)
            $display("MISMATCH at %0t: %s", $realtime, msg);
    endfunction

    function automatic string reading_text(input gauge_reading_t r);
        return $sformatf("raw=%0d mv=%0d pct=%0d valid=%0d", r.raw, r.mv, r.pct, r.ok);
    endfunction

    function automatic attempt_row_t attempt_row(input bit [11:0] smp, input bit ok,
                                                 input bit lst, input bit typed,
                                                 input bit [11:0] raw, input bit [12:0] mv,
                                                 input bit [6:0] pct, input bit valid);
        attempt_row_t row;
        row.smp      = smp;
        row.ok       = ok;
        row.lst      = lst;
        row.typed    = typed;
        row.want.raw = raw;
        row.want.mv  = mv;
        row.want.pct = pct;
        row.want.ok  = valid;
        return row;
    endfunction

    // ------------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------------

    // Offers one attempt and waits until it is taken. s_tvalid is left high
    // on return, so the caller either offers the next attempt in the same
    // step or lowers it through settle_block.
    task automatic offer_attempt(input bit [11:0] smp, input bit ok, input bit lst,
                                 input bit typed, input gauge_reading_t typed_want);
        gauge_reading_t predicted;
        bit             emits;
        if (!steady) begin
            while ($urandom_range(99) < 13) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, smp};
        s_tuser  <= ok;
        s_tlast  <= lst;
        do @(posedge aclk); while (!s_tready);
        predicted = gauge_step(smp, ok, lst, emits);
        attempts_sent++;
        if (emits) begin
            bursts_sent++;
            expected_readings.push_back(typed ? typed_want : predicted);
        end
    endtask

    // Mostly samples in the band where the charge curve bends, the rest
    // anywhere in the ADC range or right at its ends.
    function automatic bit [11:0] pick_sample();
        case ($urandom_range(3))
            0:       return 12'($urandom_range(4095));
            1, 2:    return 12'($urandom_range(4095, 3250));
            default: return $urandom_range(1) ? 12'hFFF : 12'h000;
        endcase
    endfunction

    // A burst of one to eight attempts, sometimes longer than the sample
    // limit; now and then every attempt of a burst fails.
    task automatic random_burst();
        int len;
        bit dud;
        len = ($urandom_range(9) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 1);
        dud = ($urandom_range(11) == 0);
        for (int i = 0; i < len; i++)
            offer_attempt(pick_sample(), !dud && ($urandom_range(99) < 85),
                          i == len - 1, 1'b0, '0);
    endtask

    // Stops offering, waits until every expected reading has come out and
    // then lets the given number of further cycles pass.
    task automatic settle_block(input int extra);
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_readings.size() != 0 && waited < 50000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (extra) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------------
    // APB
    // ------------------------------------------------------------------------

    task automatic write_full_mv(input bit [12:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= FULL_MV_ADDR;
        pwdata  <= {19'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        full_mv = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic check_full_mv_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= FULL_MV_ADDR;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== {19'd0, full_mv})
            note_failure($sformatf("full_millivolts read back %0d, expected %0d",
                                   prdata, full_mv));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------------

    // The receiver stalls at random, not at all while steady is high, and
    // for a long stretch each time hold_req toggles.
    always @(posedge aclk) begin : receiver
        int   hold_left;
        logic hold_seen;
        if (!aresetn) begin
            m_tready  <= 1'b0;
            hold_left = 0;
            hold_seen = 1'b0;
        end else if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 13);
        end
    end

    // Every accepted result item is matched against the oldest expectation.
    always @(posedge aclk) begin : result_monitor
        gauge_reading_t got;
        gauge_reading_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.raw = m_tdata[11:0];
            got.mv  = m_tdata[24:12];
            got.pct = m_tdata[31:25];
            got.ok  = m_tuser[0];
            readings_seen++;
            if (!got.ok)
                empty_readings++;
            if (expected_readings.size() == 0) begin
                note_failure({"result with none expected: ", reading_text(got)});
            end else begin
                want = expected_readings.pop_front();
                if (got.raw != want.raw || got.mv != want.mv ||
                    got.pct != want.pct || got.ok != want.ok)
                    note_failure({"expected ", reading_text(want),
                                  ", got ", reading_text(got)});
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    initial begin : stimulus
        attempt_row_t   directed[$];
        bit [12:0]      full_settings[5];
        int             phase_base;
        bit             paused;

        // Full points: both ends of the useful range, the point at which the
        // top segment vanishes, the largest value the register holds, and
        // finally back to the value after reset.
        full_settings = '{13'd4001, 13'd4500, 13'd4000, 13'd8191, 13'd4120};

        // No good sample since reset: invalid, all held values still zero.
        directed.push_back(attempt_row(12'd0, 1'b0, 1'b1, 1'b1, 12'd0, 13'd0, 7'd0, 1'b0));
        // Top of the ADC range gives the highest voltage, above the full point.
        directed.push_back(attempt_row(12'd4095, 1'b1, 1'b1, 1'b1,
                                       12'd4095, 13'd4125, 7'd100, 1'b1));
        // A good zero sample is a valid empty battery.
        directed.push_back(attempt_row(12'd0, 1'b1, 1'b1, 1'b1, 12'd0, 13'd0, 7'd0, 1'b1));
        // Just above the empty point, then a failed burst that must repeat it.
        directed.push_back(attempt_row(12'd3300, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd2000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd4095, 1'b0, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        // Eight good samples fill the burst; the two zeros after them are dropped.
        for (int i = 0; i < MAX_SAMPLES; i++)
            directed.push_back(attempt_row(12'd4095, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd0, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd0, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        // Samples landing on the 3600, 3800 and 4000 mV breakpoints and on
        // either side of the full point.
        directed.push_back(attempt_row(12'd3574, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd3773, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd3971, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd4090, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd4091, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));
        // A mixed burst whose failed attempt must not enter the mean.
        directed.push_back(attempt_row(12'd100, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd201, 1'b1, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd3000, 1'b0, 1'b0, 1'b0, '0, '0, '0, 1'b0));
        directed.push_back(attempt_row(12'd302, 1'b1, 1'b1, 1'b0, '0, '0, '0, 1'b0));

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        check_full_mv_readback();

        foreach (directed[i])
            offer_attempt(directed[i].smp, directed[i].ok, directed[i].lst,
                          directed[i].typed, directed[i].want);
        settle_block(SETTLE_CYCLES);

        for (int phase = 0; phase < 5; phase++) begin
            write_full_mv(full_settings[phase]);
            check_full_mv_readback();
            settings_tried++;
            // First setting: the receiver stalls for a long while so that
            // the output slot fills and the block pushes back on its input.
            if (phase == 0)
                hold_req <= ~hold_req;
            // Second setting: a whole phase without idling on either side.
            if (phase == 1)
                steady <= 1'b1;
            phase_base = attempts_sent;
            paused     = 1'b0;
            while (attempts_sent - phase_base < PHASE_ITEMS) begin
                // Third setting: halfway through, stop and let the block empty.
                if (phase == 2 && !paused && attempts_sent - phase_base >= PHASE_ITEMS / 2) begin
                    settle_block(0);
                    paused = 1'b1;
                end
                random_burst();
            end
            settle_block(SETTLE_CYCLES);
            steady <= 1'b0;
        end

        while (expected_readings.size() != 0) begin
            note_failure({"no result for ", reading_text(expected_readings.pop_front())});
        end

        $display("Sent %0d attempts in %0d bursts under %0d full-point settings.",
                 attempts_sent, bursts_sent, settings_tried);
        $display("Checked %0d results, %0d of them from bursts without a good sample.",
                 readings_seen, empty_readings);
        if (failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Far beyond the slowest correct run.
    initial begin : watchdog
        #(10_000_000);
        $display("Run timed out with %0d results still expected.", expected_readings.size());
        $display("Some tests failed");
        $finish;
    end

endmodule
